### hw/rtl/clp_pkg.sv
// clp_pkg: types, codes and keyword tables for the capability list parser.
// No dependencies; imported by capability_list_parser_unit and its checker.
`default_nettype none

package clp_pkg;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharF     = 8'h66;
  localparam logic [7:0] CharP     = 8'h70;
  localparam logic [7:0] CharA     = 8'h61;

  localparam int unsigned NumKw = 3;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_MATCH = 3'd1,
    PH_DONE  = 3'd2,
    PH_TRAIL = 3'd3
  } clp_phase_e;

  typedef enum logic [1:0] {
    KW_FRAG  = 2'd0,
    KW_PIPE  = 2'd1,
    KW_ASYNC = 2'd2
  } clp_kw_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       last;
  } clp_in_t;

  typedef struct packed {
    logic cap_fragmentation;
    logic cap_pipelining;
    logic cap_async;
    logic list_error;
  } clp_out_t;

  // keyword text, first character in the top byte, zero padded
  localparam logic [127:0] KwTextFrag  = {"fragmentation", 24'h0};
  localparam logic [127:0] KwTextPipe  = {"pipelining", 48'h0};
  localparam logic [127:0] KwTextAsync = {"async", 88'h0};

  function automatic logic [7:0] kw_char(clp_kw_e k, logic [3:0] pos);
    logic [127:0] txt;
    logic [127:0] sh;
    unique case (k)
      KW_FRAG:  txt = KwTextFrag;
      KW_PIPE:  txt = KwTextPipe;
      KW_ASYNC: txt = KwTextAsync;
      default:  txt = KwTextFrag;
    endcase
    sh = txt << {pos, 3'b000};
    return sh[127:120];
  endfunction

  function automatic logic [3:0] kw_len(clp_kw_e k);
    logic [3:0] len;
    unique case (k)
      KW_FRAG:  len = 4'd13;
      KW_PIPE:  len = 4'd10;
      KW_ASYNC: len = 4'd5;
      default:  len = 4'd13;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/capability_list_parser_unit.sv
// capability_list_parser_unit: byte-serial checker of a comma-separated
// capability list. Depends on clp_pkg.
`default_nettype none

// At most one byte per item, one item per cycle. Each accepted item updates the parse
// state (phase, keyword, match position, flags, sticky error) through a single
// level of compare-and-select logic. An item marked last also loads the result
// register and clears the parse state, so the next list may begin in the very
// next cycle. The result register holds a finished result while it waits;
// input is stalled only when that register is full and not being drained.
// The result of a list is valid in the cycle after its last item is accepted.
module capability_list_parser_unit
  import clp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire clp_in_t  in_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output clp_out_t      out_o
);

  clp_phase_e phase_q, phase_d;
  clp_kw_e    kw_q, kw_d;
  logic [3:0] pos_q, pos_d;
  logic [2:0] flags_q, flags_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;
  clp_out_t   out_q, out_d;

  logic       in_acc;
  logic [7:0] c;
  logic       is_delim;
  logic [2:0] kw_bit;
  logic [7:0] exp_char;
  logic [3:0] len;
  logic [3:0] pos_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign c          = in_i.char_byte;
  assign is_delim   = (c == CharSpace) || (c == CharComma);
  assign kw_bit     = 3'b001 << kw_q;
  assign exp_char   = kw_char(kw_q, pos_q);
  assign len        = kw_len(kw_q);
  assign pos_inc    = pos_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    kw_d        = kw_q;
    pos_d       = pos_q;
    flags_d     = flags_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (in_acc) begin
      if (in_i.has_byte && !err_q) begin
        unique case (phase_q)
          PH_LEAD: begin
            if (is_delim) begin
              phase_d = PH_LEAD;
            end else if (c == CharF || c == CharP || c == CharA) begin
              kw_d    = (c == CharF) ? KW_FRAG : ((c == CharP) ? KW_PIPE : KW_ASYNC);
              pos_d   = 4'd1;
              phase_d = PH_MATCH;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_MATCH: begin
            if (pos_q < len && c == exp_char) begin
              pos_d = pos_inc;
              if (pos_inc == len) begin
                phase_d = PH_DONE;
              end
            end else begin
              err_d = 1'b1;
            end
          end
          PH_DONE: begin
            if (is_delim) begin
              flags_d = flags_q | kw_bit;
              phase_d = (c == CharComma) ? PH_LEAD : PH_TRAIL;
            end else begin
              err_d = 1'b1;
            end
          end
          default: begin
            if (c == CharComma) begin
              phase_d = PH_LEAD;
            end else if (c != CharSpace) begin
              err_d = 1'b1;
            end
          end
        endcase
      end

      if (in_i.last) begin
        if (!err_d) begin
          if (phase_d == PH_DONE) begin
            flags_d = flags_d | (3'b001 << kw_d);
          end else if (phase_d == PH_MATCH) begin
            err_d = 1'b1;
          end
        end
        out_d.cap_fragmentation = flags_d[0];
        out_d.cap_pipelining    = flags_d[1];
        out_d.cap_async         = flags_d[2];
        out_d.list_error        = err_d;
        out_valid_d             = 1'b1;
        phase_d                 = PH_LEAD;
        kw_d                    = KW_FRAG;
        pos_d                   = 4'd0;
        flags_d                 = 3'b000;
        err_d                   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      kw_q        <= KW_FRAG;
      pos_q       <= 4'd0;
      flags_q     <= 3'b000;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      kw_q        <= kw_d;
      pos_q       <= pos_d;
      flags_q     <= flags_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

### hw/rtl/clp_checker.sv
// clp_checker: port-level checks for capability_list_parser_unit, with bind.
// Depends on clp_pkg.
`default_nettype none

module clp_checker
  import clp_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire clp_in_t  in_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire clp_out_t out_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // last item yields a result next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.last |=> out_valid_o)
    else $error("no result after last item");

  // items that are not last do not invent a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && in_ready_o && in_i.last) |=> !out_valid_o)
    else $error("result without last item");

  // a pending result is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted over pending result");

endmodule

bind capability_list_parser_unit clp_checker u_clp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
